// ===== src/qft_pkg.sv =====
// ----------------------------------------------------------------------------
// qft_pkg: shared types and constants for the quoted field tokenizer
// Scan modes, byte codes and the state/result records passed between modules.
// ----------------------------------------------------------------------------
package qft_pkg;

    typedef enum logic [2:0] {
        MODE_LEAD   = 3'd0,
        MODE_TOKEN  = 3'd1,
        MODE_SKIP   = 3'd2,
        MODE_QUOTED = 3'd3,
        MODE_DONE   = 3'd4
    } mode_t;

    localparam logic [7:0]  BYTE_NUL     = 8'd0;
    localparam logic [7:0]  BYTE_TAB     = 8'd9;
    localparam logic [7:0]  BYTE_CR      = 8'd13;
    localparam logic [7:0]  BYTE_NEWLINE = 8'd10;
    localparam logic [7:0]  BYTE_QUOTE   = 8'd34;
    localparam logic [7:0]  BYTE_SPACE   = 8'd32;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] tokens;
        logic        quote_err;
    } scan_state_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        char_valid;
        logic        token_begin;
        logic [15:0] token_count;
        logic        finished;
        logic        unbalanced_quote;
    } scan_result_t;

endpackage

// ===== src/qft_scan.sv =====
// ----------------------------------------------------------------------------
// qft_scan: per-byte decision logic
// Classifies one byte against the current scan state, giving the result
// record and the state that follows it.
// ----------------------------------------------------------------------------
module qft_scan (
    input  qft_pkg::scan_state_t  state_cur,
    input  logic [7:0]            text_byte,
    input  logic                  last_byte,
    input  logic [7:0]            delimiter,
    output qft_pkg::scan_state_t  state_next,
    output qft_pkg::scan_result_t result
);

    logic        is_white;
    logic        is_term;
    logic        is_delim;
    logic        at_start;
    logic        valid;
    logic        err;
    logic [15:0] count;
    qft_pkg::mode_t mode;

    assign is_white = ((text_byte >= qft_pkg::BYTE_TAB) && (text_byte <= qft_pkg::BYTE_CR))
                      || (text_byte == qft_pkg::BYTE_SPACE);
    assign is_term  = (text_byte == qft_pkg::BYTE_NUL) || (text_byte == qft_pkg::BYTE_NEWLINE);
    assign is_delim = (text_byte == delimiter);

    always_comb begin
        mode     = state_cur.mode;
        err      = state_cur.quote_err;
        count    = state_cur.tokens;
        valid    = 1'b0;
        at_start = 1'b0;

        unique case (state_cur.mode)
            qft_pkg::MODE_LEAD: begin
                // newline is whitespace here; only NUL ends the string
                if (text_byte == qft_pkg::BYTE_NUL) begin
                    mode = qft_pkg::MODE_DONE;
                end else if (!is_white) begin
                    at_start = 1'b1;
                end
            end
            qft_pkg::MODE_TOKEN: begin
                if (is_term) begin
                    mode = qft_pkg::MODE_DONE;
                end else if (is_delim) begin
                    mode = qft_pkg::MODE_SKIP;
                end else begin
                    valid = 1'b1;
                end
            end
            qft_pkg::MODE_SKIP: begin
                if (is_term) begin
                    mode = qft_pkg::MODE_DONE;
                end else if (!is_delim) begin
                    at_start = 1'b1;
                end
            end
            qft_pkg::MODE_QUOTED: begin
                if (is_term) begin
                    err  = 1'b1;
                    mode = qft_pkg::MODE_DONE;
                end else if (text_byte == qft_pkg::BYTE_QUOTE) begin
                    mode = qft_pkg::MODE_SKIP;
                end else begin
                    valid = 1'b1;
                end
            end
            default: begin
                mode = qft_pkg::MODE_DONE;
            end
        endcase

        if (at_start) begin
            if (count != qft_pkg::COUNT_MAX) begin
                count = count + 16'd1;
            end
            // quote is tested before the delimiter at a token start
            priority if (text_byte == qft_pkg::BYTE_QUOTE) begin
                mode = qft_pkg::MODE_QUOTED;
            end else if (is_delim) begin
                mode = qft_pkg::MODE_SKIP;
            end else begin
                mode  = qft_pkg::MODE_TOKEN;
                valid = 1'b1;
            end
        end

        result.char_out         = text_byte;
        result.char_valid       = valid;
        result.token_begin      = at_start;
        result.token_count      = count;
        result.finished         = last_byte;
        result.unbalanced_quote = last_byte && ((mode == qft_pkg::MODE_QUOTED) || err);

        if (last_byte) begin
            state_next.mode      = qft_pkg::MODE_LEAD;
            state_next.tokens    = '0;
            state_next.quote_err = 1'b0;
        end else begin
            state_next.mode      = mode;
            state_next.tokens    = count;
            state_next.quote_err = err;
        end
    end

endmodule

// ===== src/quoted_field_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// quoted_field_tokenizer_unit: streaming tokenizer with quoted fields
// One string byte per item in, one result item per byte out.
// ----------------------------------------------------------------------------
// Accepts one byte every clock cycle while the result side is not stalled and
// returns one result per byte. Each accepted item passes through the input
// register, then the result register. The scan-mode register and the
// saturating token counter are updated as each item moves from the input
// register to the result register. Either side may stall; the input register
// refills while a finished result waits. The delimiter register resets to space
// and should be written only while no item is in flight.
module quoted_field_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_out,
    output logic        m_char_valid,
    output logic        m_token_begin,
    output logic [15:0] m_token_count,
    output logic        m_finished,
    output logic        m_unbalanced_quote
);

    logic [7:0]            delim_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  out_valid_reg;
    qft_pkg::scan_result_t out_reg;
    qft_pkg::scan_state_t  state_reg;
    qft_pkg::scan_state_t  state_next;
    qft_pkg::scan_result_t result_next;
    logic                  advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    qft_scan u_scan (
        .state_cur  (state_reg),
        .text_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .delimiter  (delim_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= qft_pkg::BYTE_SPACE;
        end else if (cfg_wr_en) begin
            delim_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_last_reg <= s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            state_reg.mode      <= qft_pkg::MODE_LEAD;
            state_reg.tokens    <= '0;
            state_reg.quote_err <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_char_out         = out_reg.char_out;
    assign m_char_valid       = out_reg.char_valid;
    assign m_token_begin      = out_reg.token_begin;
    assign m_token_count      = out_reg.token_count;
    assign m_finished         = out_reg.finished;
    assign m_unbalanced_quote = out_reg.unbalanced_quote;

`ifndef SYNTHESIS
    // a finished string leaves the scanner cleared for the next one
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> state_reg.mode == qft_pkg::MODE_LEAD
            && state_reg.tokens == 16'd0 && !state_reg.quote_err)
        else $error("scan state not cleared after last item");

    // once ended, a string stays ended until its last byte
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_last_reg && state_reg.mode == qft_pkg::MODE_DONE
            |=> state_reg.mode == qft_pkg::MODE_DONE)
        else $error("ended string resumed scanning");

    // a token start always leaves a nonzero count
    a_begin_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_begin |-> m_token_count != 16'd0)
        else $error("token begin with zero count");

    // the quote error flag only ever appears on a finished item
    a_unbal_final: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result_next.unbalanced_quote |-> in_last_reg)
        else $error("unbalanced quote reported before last item");

    // the counter never drops within a string
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_last_reg |=> state_reg.tokens >= $past(state_reg.tokens))
        else $error("token counter decreased");
`endif

endmodule
